// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define AST_SAME(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define AST_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/hbe_pkg.sv =====
// Types and constants of the byte Huffman encoder
package hbe_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 64;
  localparam int COUNT_WIDTH  = 32;

  localparam int NODES    = 2 * SYMBOLS - 1;
  localparam int SYM_W    = $clog2(SYMBOLS);
  localparam int NODE_W   = $clog2(NODES);
  localparam int WEIGHT_W = COUNT_WIDTH + 8;
  localparam int LEN_W    = $clog2(MAX_CODE_LEN + 1);

  localparam logic [8:0] SYM_LIM = 9'(SYMBOLS);

  typedef struct packed {
    logic       pass;
    logic [7:0] sym;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_count;
    logic       overflow;
    logic       end_of_run;
  } out_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                live;
    logic                linked;
    logic                side;
    logic [NODE_W-1:0]   parent;
  } node_t;

endpackage

// ===== rtl/huffman_byte_encoder_core.sv =====
// Two-pass static Huffman byte encoder: histogram, tree build, code stream
// Counting byte: histogram read, then increment. Encoding byte: code table read, code load,
// bit shift-out (held by output stalls), then padding and bit count when last. The first
// encoding byte adds the tree build: leaf load, a scan per merge, a final scan, code walk.
// Scan, merge and walk share one node memory; each scan keeps the two lightest live nodes.
// Reset (rst, synchronous) clears control state, histogram valid bits and the bit stream.
`include "assert_macros.svh"

module huffman_byte_encoder_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         src_valid,
  output logic         src_stall,
  input  hbe_pkg::in_t src_data,
  output logic         dst_valid,
  input  logic         dst_stall,
  output hbe_pkg::out_t dst_data
);
  import hbe_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_HINC     = 5'd1;
  localparam logic [4:0] S_INIT_RD  = 5'd2;
  localparam logic [4:0] S_INIT_WR  = 5'd3;
  localparam logic [4:0] S_SCAN     = 5'd4;
  localparam logic [4:0] S_SCAN_END = 5'd5;
  localparam logic [4:0] S_DECIDE   = 5'd6;
  localparam logic [4:0] S_MA       = 5'd7;
  localparam logic [4:0] S_MB       = 5'd8;
  localparam logic [4:0] S_MN       = 5'd9;
  localparam logic [4:0] S_WRD      = 5'd10;
  localparam logic [4:0] S_WCHK     = 5'd11;
  localparam logic [4:0] S_CRD      = 5'd12;
  localparam logic [4:0] S_CLD      = 5'd13;
  localparam logic [4:0] S_SHIFT    = 5'd14;
  localparam logic [4:0] S_PAD      = 5'd15;
  localparam logic [4:0] S_CNT      = 5'd16;

  localparam logic [NODE_W-1:0] LAST_SYM = NODE_W'(SYMBOLS - 1);
  localparam logic [NODE_W-1:0] FIRST_INT = NODE_W'(SYMBOLS);
  localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(MAX_CODE_LEN);
  localparam logic [LEN_W-1:0]  LEN_BYTE = LEN_W'(8);

  logic [COUNT_WIDTH-1:0]  hist_mem [SYMBOLS];
  logic [SYMBOLS-1:0]      hist_vld;
  node_t                   node_mem [NODES];
  logic [LEN_W-1:0]        len_mem  [SYMBOLS];
  logic [MAX_CODE_LEN-1:0] code_mem [SYMBOLS];

  logic [COUNT_WIDTH-1:0]  hist_q;
  logic                    hist_vq;
  node_t                   node_q;
  logic [LEN_W-1:0]        len_q;
  logic [MAX_CODE_LEN-1:0] code_q;

  logic [4:0]              state;
  in_t                     in_q;
  logic [NODE_W-1:0]       cnt;
  logic [NODE_W-1:0]       n_nodes;
  logic [NODE_W-1:0]       x;
  logic [NODE_W-1:0]       b1, b2, cmp_idx;
  logic [WEIGHT_W-1:0]     w1, w2;
  logic                    f1, f2, cmp_vld;
  logic [LEN_W-1:0]        clen, rem_len;
  logic [MAX_CODE_LEN-1:0] creg, sh;
  logic                    tree_ready, ovf;
  logic [7:0]              acc;
  logic [2:0]              bcnt;
  logic                    out_valid;
  out_t                    out_q;

  logic [SYM_W-1:0]        hist_ra;
  logic [COUNT_WIDTH-1:0]  hist_val;
  logic                    hist_we;
  logic [NODE_W-1:0]       node_ra, node_wa;
  logic                    node_we;
  node_t                   node_wd;
  logic                    code_we;
  logic                    sym_ok;
  logic                    slot_free;
  logic                    out_load;
  out_t                    out_next;

  assign src_stall = (state != S_IDLE);
  assign dst_valid = out_valid;
  assign dst_data  = out_q;
  assign slot_free = !out_valid || !dst_stall;
  assign sym_ok    = {1'b0, in_q.sym} < SYM_LIM;
  assign hist_val  = hist_vq ? hist_q : '0;
  assign hist_ra   = (state == S_IDLE) ? src_data.sym[SYM_W-1:0] : cnt[SYM_W-1:0];
  assign hist_we   = (state == S_HINC) && (hist_val != '1);
  assign node_ra   = (state == S_SCAN) ? cnt : x;
  assign code_we   = (state == S_WCHK) && !node_q.linked;

  always_comb begin
    node_we = 1'b0;
    node_wa = cnt;
    node_wd = '0;
    case (state)
      S_INIT_WR: begin
        node_we        = 1'b1;
        node_wd.weight = WEIGHT_W'(hist_val);
        node_wd.live   = (hist_val != '0);
      end
      S_MA: begin
        node_we        = 1'b1;
        node_wa        = b1;
        node_wd.weight = w1;
        node_wd.linked = 1'b1;
        node_wd.parent = n_nodes;
      end
      S_MB: begin
        node_we        = 1'b1;
        node_wa        = b2;
        node_wd.weight = w2;
        node_wd.linked = 1'b1;
        node_wd.side   = 1'b1;
        node_wd.parent = n_nodes;
      end
      S_MN: begin
        node_we        = 1'b1;
        node_wa        = n_nodes;
        node_wd.weight = w1 + w2;
        node_wd.live   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_load            = 1'b0;
    out_next.out_byte   = {acc[6:0], sh[MAX_CODE_LEN-1]};
    out_next.is_count   = 1'b0;
    out_next.overflow   = ovf;
    out_next.end_of_run = 1'b0;
    case (state)
      S_SHIFT: begin
        out_load            = (rem_len != '0) && (bcnt == 3'd7) && slot_free;
        out_next.end_of_run = !in_q.last && (LEN_W'(rem_len - 1'b1) < LEN_BYTE);
      end
      S_PAD: begin
        out_load          = (bcnt != 3'd0) && slot_free;
        out_next.out_byte = acc << (4'd8 - {1'b0, bcnt});
      end
      S_CNT: begin
        out_load            = slot_free;
        out_next.out_byte   = {5'd0, bcnt};
        out_next.is_count   = 1'b1;
        out_next.end_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hist_q  <= hist_mem[hist_ra];
    hist_vq <= hist_vld[hist_ra];
    if (hist_we) begin
      hist_mem[in_q.sym[SYM_W-1:0]] <= hist_val + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    node_q <= node_mem[node_ra];
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
  end

  always_ff @(posedge clk) begin
    len_q  <= len_mem[in_q.sym[SYM_W-1:0]];
    code_q <= code_mem[in_q.sym[SYM_W-1:0]];
    if (code_we) begin
      len_mem[cnt[SYM_W-1:0]]  <= clen;
      code_mem[cnt[SYM_W-1:0]] <= creg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tree_ready <= 1'b0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= '0;
      bcnt       <= '0;
      hist_vld   <= '0;
      cmp_vld    <= 1'b0;
      f1         <= 1'b0;
      f2         <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN);
      cmp_idx <= cnt;

      if (out_load) begin
        out_valid <= 1'b1;
        out_q     <= out_next;
      end else if (!dst_stall) begin
        out_valid <= 1'b0;
      end

      if (cmp_vld && node_q.live) begin
        if (!f1 || node_q.weight < w1) begin
          b2 <= b1;
          w2 <= w1;
          f2 <= f1;
          b1 <= cmp_idx;
          w1 <= node_q.weight;
          f1 <= 1'b1;
        end else if (!f2 || node_q.weight < w2) begin
          b2 <= cmp_idx;
          w2 <= node_q.weight;
          f2 <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (src_valid) begin
            in_q <= src_data;
            if (!src_data.pass) begin
              if (!tree_ready && ({1'b0, src_data.sym} < SYM_LIM)) begin
                state <= S_HINC;
              end
            end else if (tree_ready) begin
              state <= S_CRD;
            end else begin
              cnt   <= '0;
              state <= S_INIT_RD;
            end
          end
        end
        S_HINC: begin
          hist_vld[in_q.sym[SYM_W-1:0]] <= 1'b1;
          state <= S_IDLE;
        end
        S_INIT_RD: begin
          state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          if (cnt == LAST_SYM) begin
            cnt     <= '0;
            n_nodes <= FIRST_INT;
            f1      <= 1'b0;
            f2      <= 1'b0;
            state   <= S_SCAN;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_INIT_RD;
          end
        end
        S_SCAN: begin
          if (cnt == NODE_W'(n_nodes - 1'b1)) begin
            state <= S_SCAN_END;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN_END: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (f2) begin
            state <= S_MA;
          end else begin
            cnt   <= '0;
            x     <= '0;
            clen  <= '0;
            creg  <= '0;
            state <= S_WRD;
          end
        end
        S_MA: begin
          state <= S_MB;
        end
        S_MB: begin
          state <= S_MN;
        end
        S_MN: begin
          n_nodes <= n_nodes + 1'b1;
          cnt     <= '0;
          f1      <= 1'b0;
          f2      <= 1'b0;
          state   <= S_SCAN;
        end
        S_WRD: begin
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (node_q.linked) begin
            x    <= node_q.parent;
            creg <= {node_q.side, creg[MAX_CODE_LEN-1:1]};
            if (clen == LEN_MAX) begin
              ovf <= 1'b1;
            end else begin
              clen <= clen + 1'b1;
            end
            state <= S_WRD;
          end else if (cnt == LAST_SYM) begin
            tree_ready <= 1'b1;
            state      <= S_CRD;
          end else begin
            cnt   <= cnt + 1'b1;
            x     <= cnt + 1'b1;
            clen  <= '0;
            creg  <= '0;
            state <= S_WRD;
          end
        end
        S_CRD: begin
          state <= S_CLD;
        end
        S_CLD: begin
          rem_len <= sym_ok ? len_q : '0;
          sh      <= code_q;
          state   <= S_SHIFT;
        end
        S_SHIFT: begin
          if (rem_len == '0) begin
            state <= in_q.last ? S_PAD : S_IDLE;
          end else if (bcnt != 3'd7) begin
            acc     <= {acc[6:0], sh[MAX_CODE_LEN-1]};
            bcnt    <= bcnt + 1'b1;
            sh      <= sh << 1;
            rem_len <= rem_len - 1'b1;
          end else if (slot_free) begin
            acc     <= '0;
            bcnt    <= '0;
            sh      <= sh << 1;
            rem_len <= rem_len - 1'b1;
          end
        end
        S_PAD: begin
          if (bcnt == 3'd0 || slot_free) begin
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (slot_free) begin
            hist_vld   <= '0;
            acc        <= '0;
            bcnt       <= '0;
            tree_ready <= 1'b0;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `AST_SAME(a_emit_slot, clk, rst, out_load, !out_valid || !dst_stall)
  `AST_NEXT(a_run_clear, clk, rst, out_load && out_next.is_count, !tree_ready && bcnt == 3'd0)
  `AST_SAME(a_pick_order, clk, rst, state == S_DECIDE && f2, w1 <= w2)
  `AST_SAME(a_encode_tree, clk, rst, state == S_CRD || state == S_SHIFT, tree_ready)

endmodule
